### hdl/dod_pkg.sv
// ----------------------------------------------------------------------------
// dod_pkg
// shared widths, constants and pipeline bundles of the displacement damper
// ----------------------------------------------------------------------------
package dod_pkg;

    localparam int LEN_W     = 32;
    localparam int SUMSQ_W   = 2 * LEN_W;
    localparam int MAXD_W    = 31;
    localparam int FRAC_BITS = 16;
    localparam int COS_BITS  = 30;
    localparam int LIM_W     = 34;

    localparam logic [MAXD_W-1:0] MAXD_RESET   = MAXD_W'(10 << FRAC_BITS);
    localparam logic [COS_BITS:0] COS_ONE      = (COS_BITS + 1)'(1) << COS_BITS;
    localparam logic [COS_BITS:0] ONE_POINT_TWO = 31'd1288490189;

    localparam logic REG_MAXD = 1'b0;

    typedef logic [2:0][LEN_W-1:0] vec3_t;

    typedef struct packed {
        vec3_t      nm;
        logic [2:0] nn;
        vec3_t      pm;
        logic [2:0] pn;
    } sqrt_side_t;

    typedef struct packed {
        sqrt_side_t        v;
        logic [LEN_W-1:0] nl;
        logic [LEN_W-1:0] pl;
        logic              clamp;
    } clamp_side_t;

    typedef struct packed {
        vec3_t             nm;
        logic [2:0]        nn;
        logic [LEN_W-1:0] nl;
        logic [LEN_W-1:0] pl;
    } core_t;

    typedef struct packed {
        core_t c;
        logic  dneg;
        logic  sat;
        logic  active;
    } frac_side_t;

    typedef struct packed {
        vec3_t      nm;
        logic [2:0] nn;
        logic       damp;
    } out_side_t;

endpackage

### hdl/dod_sqrt.sv
// ----------------------------------------------------------------------------
// dod_sqrt
// pipelined integer square root, one root bit per stage, several lanes
// ----------------------------------------------------------------------------
module dod_sqrt #(
    parameter int LANES = 2,
    parameter int SW    = 1
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [LANES-1:0][dod_pkg::SUMSQ_W-1:0] value,
    input  logic [SW-1:0]                         side_in,
    output logic [LANES-1:0][dod_pkg::LEN_W-1:0]   root,
    output logic [SW-1:0]                         side_out
);

    localparam int STAGES = dod_pkg::LEN_W;
    localparam int REM_W  = dod_pkg::LEN_W + 2;
    localparam int VW     = dod_pkg::SUMSQ_W;
    localparam int RW     = dod_pkg::LEN_W;

    logic [REM_W-1:0] rem_reg  [STAGES][LANES];
    logic [RW-1:0]    root_reg [STAGES][LANES];
    logic [VW-1:0]    val_reg  [STAGES][LANES];
    logic [SW-1:0]    side_reg [STAGES];

    logic [REM_W-1:0] rem_in    [STAGES][LANES];
    logic [RW-1:0]    root_in   [STAGES][LANES];
    logic [VW-1:0]    val_in    [STAGES][LANES];
    logic [REM_W:0]   cand      [STAGES][LANES];
    logic [REM_W:0]   trial     [STAGES][LANES];
    logic [REM_W-1:0] rem_next  [STAGES][LANES];
    logic [RW-1:0]    root_next [STAGES][LANES];
    logic [VW-1:0]    val_next  [STAGES][LANES];
    logic [SW-1:0]    side_next [STAGES];

    always_comb
    begin
        side_next[0] = side_in;
        for (int l = 0; l < LANES; l++)
        begin
            rem_in[0][l]  = '0;
            root_in[0][l] = '0;
            val_in[0][l]  = value[l];
        end
        for (int k = 1; k < STAGES; k++)
        begin
            side_next[k] = side_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                rem_in[k][l]  = rem_reg[k-1][l];
                root_in[k][l] = root_reg[k-1][l];
                val_in[k][l]  = val_reg[k-1][l];
            end
        end
        for (int k = 0; k < STAGES; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cand[k][l]  = {rem_in[k][l][REM_W-2:0], val_in[k][l][VW-1 -: 2]};
                trial[k][l] = {1'b0, root_in[k][l], 2'b01};
                if (cand[k][l] >= trial[k][l])
                begin
                    rem_next[k][l]  = REM_W'(cand[k][l] - trial[k][l]);
                    root_next[k][l] = {root_in[k][l][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][l]  = cand[k][l][REM_W-1:0];
                    root_next[k][l] = {root_in[k][l][RW-2:0], 1'b0};
                end
                val_next[k][l] = {val_in[k][l][VW-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                side_reg[k] <= side_next[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l]  <= rem_next[k][l];
                    root_reg[k][l] <= root_next[k][l];
                    val_reg[k][l]  <= val_next[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root[l] = root_reg[STAGES-1][l];
        end
    end

    assign side_out = side_reg[STAGES-1];

endmodule

### hdl/dod_div.sv
// ----------------------------------------------------------------------------
// dod_div
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module dod_div #(
    parameter int LANES = 1,
    parameter int NW    = 64,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int SW    = 1
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [LANES-1:0][NW-1:0]  num,
    input  logic [DW-1:0]             den,
    input  logic [SW-1:0]             side_in,
    output logic [LANES-1:0][QW-1:0]  quo,
    output logic [SW-1:0]             side_out
);

    logic [DW-1:0] r_reg    [QW][LANES];
    logic [QW-1:0] low_reg  [QW][LANES];
    logic [QW-1:0] q_reg    [QW][LANES];
    logic [DW-1:0] d_reg    [QW];
    logic [SW-1:0] side_reg [QW];

    logic [DW-1:0] r_in      [QW][LANES];
    logic [QW-1:0] low_in    [QW][LANES];
    logic [QW-1:0] q_in      [QW][LANES];
    logic [DW-1:0] d_in      [QW];
    logic [DW:0]   cand      [QW][LANES];
    logic          ge        [QW][LANES];
    logic [DW-1:0] r_next    [QW][LANES];
    logic [SW-1:0] side_next [QW];

    always_comb
    begin
        d_in[0]      = den;
        side_next[0] = side_in;
        for (int l = 0; l < LANES; l++)
        begin
            r_in[0][l]   = DW'(num[l][NW-1:QW]);
            low_in[0][l] = num[l][QW-1:0];
            q_in[0][l]   = '0;
        end
        for (int k = 1; k < QW; k++)
        begin
            d_in[k]      = d_reg[k-1];
            side_next[k] = side_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                r_in[k][l]   = r_reg[k-1][l];
                low_in[k][l] = low_reg[k-1][l];
                q_in[k][l]   = q_reg[k-1][l];
            end
        end
        for (int k = 0; k < QW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cand[k][l] = {r_in[k][l], low_in[k][l][QW-1]};
                ge[k][l]   = cand[k][l] >= {1'b0, d_in[k]};
                if (ge[k][l])
                begin
                    r_next[k][l] = DW'(cand[k][l] - {1'b0, d_in[k]});
                end
                else
                begin
                    r_next[k][l] = cand[k][l][DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                d_reg[k]    <= d_in[k];
                side_reg[k] <= side_next[k];
                for (int l = 0; l < LANES; l++)
                begin
                    r_reg[k][l]   <= r_next[k][l];
                    low_reg[k][l] <= {low_in[k][l][QW-2:0], 1'b0};
                    q_reg[k][l]   <= {q_in[k][l][QW-2:0], ge[k][l]};
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = q_reg[QW-1][l];
        end
    end

    assign side_out = side_reg[QW-1];

endmodule

### hdl/displacement_oscillation_damper.sv
// ----------------------------------------------------------------------------
// displacement_oscillation_damper
// per-node damping of 3d displacements against the stored previous step
//
//   channel  dir  transfer when                  payload
//   in       in   in_valid & in_ready            func node_index next_x/y/z
//   out      out  out_valid & out_ready          damped_x/y/z
//   apb      in   psel & penable & pwrite        length limit at 0x0
//
// one item per cycle while no hazard, clearing pass or output stall holds the input; an input
// transfer reaches the output through the square root, clamp divider, cosine divider and
// damping divider pipelines (one bit per stage)
// after reset a clearing pass zeroes every entry of the history memory
// an item whose node is still in flight waits until that one is written back
// a stalled output freezes the whole pipeline
// ----------------------------------------------------------------------------
module displacement_oscillation_damper #(
    parameter int NODE_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [9:0]         node_index,
    input  logic signed [31:0] next_x,
    input  logic signed [31:0] next_y,
    input  logic signed [31:0] next_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] damped_x,
    output logic signed [31:0] damped_y,
    output logic signed [31:0] damped_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW         = $clog2(NODE_COUNT);
    localparam int LW         = dod_pkg::LEN_W;
    localparam int CB         = dod_pkg::COS_BITS;
    localparam int PIPE_DEPTH = 4 + LW + 1 + LW + 4 + CB + 4 + LW;
    localparam int LAST       = PIPE_DEPTH - 1;
    localparam int SQ_SW      = $bits(dod_pkg::sqrt_side_t);
    localparam int CL_SW      = $bits(dod_pkg::clamp_side_t);
    localparam int FR_SW      = $bits(dod_pkg::frac_side_t);
    localparam int OS_SW      = $bits(dod_pkg::out_side_t);

    // control
    logic            adv;
    logic            acc;
    logic            hazard;
    logic            in_ok;
    logic [15:0]     idx_ext;
    logic            clearing_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic [dod_pkg::MAXD_W-1:0] maxd_reg;
    logic            out_valid_reg;
    logic            tag_vld_reg [PIPE_DEPTH];
    logic            tag_ok_reg  [PIPE_DEPTH];
    logic [9:0]      tag_idx_reg [PIPE_DEPTH];

    // history memory
    logic [95:0]     mem [NODE_COUNT];
    logic [95:0]     rd_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [95:0]     mem_wd;
    logic [15:0]     wr_idx_ext;

    // pipeline
    logic                 s0_func_reg;
    dod_pkg::vec3_t       s0_next_reg;
    dod_pkg::sqrt_side_t  a_next;
    dod_pkg::sqrt_side_t  a_reg;
    logic [1:0][2:0][63:0] b_sq_reg;
    dod_pkg::sqrt_side_t  b_reg;
    logic [1:0][63:0]     c_sum_reg;
    dod_pkg::sqrt_side_t  c_reg;
    logic [1:0][LW-1:0]   sq_root;
    dod_pkg::sqrt_side_t  sq_side;
    dod_pkg::clamp_side_t d_reg;
    logic [2:0][63:0]     d_prod_reg;
    logic [2:0][63:0]     d1_num;
    logic [LW-1:0]        d1_den;
    logic [2:0][LW-1:0]   d1_quo;
    dod_pkg::clamp_side_t d1_side;
    dod_pkg::core_t       e_reg;
    dod_pkg::vec3_t       e_pm_reg;
    logic [2:0]           e_pn_reg;
    dod_pkg::core_t       f_reg;
    logic [2:0][63:0]     f_t_reg;
    logic [2:0]           f_xs_reg;
    logic [63:0]          f_den_reg;
    dod_pkg::core_t       g1_reg;
    logic [63:0]          g1_dot_reg;
    logic [63:0]          g1_den_reg;
    dod_pkg::frac_side_t  g2_reg;
    logic [63:0]          g2_adot_reg;
    logic [63:0]          g2_den_reg;
    logic [63:0]          g2_adot_next;
    logic [0:0][CB+63:0]  fr_num;
    logic [63:0]          fr_den;
    logic [0:0][CB-1:0]   fr_quo;
    dod_pkg::frac_side_t  fr_side;
    logic [CB:0]          h_cmag;
    dod_pkg::core_t       h_reg;
    logic                 h_dneg_reg;
    logic                 h_active_reg;
    logic [2*CB+1:0]      h_sq_reg;
    logic [2*CB+1:0]      h_lin_reg;
    logic [CB+3:0]        i_fsum;
    logic [CB+3:0]        i_f;
    dod_pkg::core_t       i_reg;
    logic                 i_active_reg;
    logic [LW-1:0]        i_f_reg;
    logic [63:0]          j_prod;
    dod_pkg::core_t       j_reg;
    logic                 j_active_reg;
    logic [dod_pkg::LIM_W-1:0] j_lim_reg;
    dod_pkg::out_side_t   k_reg;
    logic [LW-1:0]        k_nl_reg;
    logic [2:0][63:0]     k_prod_reg;
    logic [2:0][63:0]     d2_num;
    logic [LW-1:0]        d2_den;
    logic [2:0][LW-1:0]   d2_quo;
    dod_pkg::out_side_t   d2_side;
    dod_pkg::vec3_t       res;
    logic [LW-1:0]        res_mag [3];
    dod_pkg::vec3_t       out_res_reg;

    // handshake
    assign adv      = !out_valid_reg || out_ready;
    assign idx_ext  = 16'(node_index);
    assign in_ok    = 17'(node_index) < 17'(NODE_COUNT);
    assign in_ready = adv && !clearing_reg && !hazard;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            if (tag_vld_reg[k] && tag_ok_reg[k] && tag_idx_reg[k] == node_index && in_ok)
            begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                tag_vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag_vld_reg[0] <= acc;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                tag_vld_reg[k] <= tag_vld_reg[k-1];
            end
            out_valid_reg <= tag_vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_ok_reg[0]  <= in_ok;
            tag_idx_reg[0] <= node_index;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                tag_ok_reg[k]  <= tag_ok_reg[k-1];
                tag_idx_reg[k] <= tag_idx_reg[k-1];
            end
        end
    end

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dod_pkg::REG_MAXD) ? {1'b0, maxd_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxd_reg <= dod_pkg::MAXD_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == dod_pkg::REG_MAXD)
        begin
            maxd_reg <= pwdata[dod_pkg::MAXD_W-1:0];
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(NODE_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // history memory
    assign wr_idx_ext = 16'(tag_idx_reg[LAST]);
    assign mem_we = clearing_reg || (adv && tag_vld_reg[LAST] && tag_ok_reg[LAST]);
    assign mem_wa = clearing_reg ? clr_addr_reg : wr_idx_ext[AW-1:0];
    assign mem_wd = clearing_reg ? 96'd0 : res;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= mem[idx_ext[AW-1:0]];
        end
    end

    // stage 0 and sign split
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_func_reg    <= func;
            s0_next_reg[0] <= next_x;
            s0_next_reg[1] <= next_y;
            s0_next_reg[2] <= next_z;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [LW-1:0] nv;
            logic [LW-1:0] pv;
            nv = s0_func_reg ? '0 : s0_next_reg[i];
            pv = tag_ok_reg[0] ? rd_reg[i*LW +: LW] : '0;
            a_next.nn[i] = nv[LW-1];
            a_next.nm[i] = nv[LW-1] ? (LW'(0) - nv) : nv;
            a_next.pn[i] = pv[LW-1];
            a_next.pm[i] = pv[LW-1] ? (LW'(0) - pv) : pv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= a_reg;
            c_reg <= b_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[0][i] <= a_reg.nm[i] * a_reg.nm[i];
                b_sq_reg[1][i] <= a_reg.pm[i] * a_reg.pm[i];
            end
            for (int l = 0; l < 2; l++)
            begin
                c_sum_reg[l] <= b_sq_reg[l][0] + b_sq_reg[l][1] + b_sq_reg[l][2];
            end
        end
    end

    dod_sqrt #(
        .LANES (2),
        .SW    (SQ_SW)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .value    (c_sum_reg),
        .side_in  (c_reg),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // length clamp
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg.v     <= sq_side;
            d_reg.nl    <= sq_root[0];
            d_reg.pl    <= sq_root[1];
            d_reg.clamp <= sq_root[0] > LW'(maxd_reg);
            for (int i = 0; i < 3; i++)
            begin
                d_prod_reg[i] <= sq_side.nm[i] * maxd_reg;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_num[i] = d_reg.clamp ? d_prod_reg[i] : 64'd0;
        end
        d1_den = d_reg.clamp ? d_reg.nl : LW'(1);
    end

    dod_div #(
        .LANES (3),
        .NW    (64),
        .DW    (LW),
        .QW    (LW),
        .SW    (CL_SW)
    ) u_div_clamp (
        .clk      (clk),
        .en       (adv),
        .num      (d1_num),
        .den      (d1_den),
        .side_in  (d_reg),
        .quo      (d1_quo),
        .side_out (d1_side)
    );

    // cosine
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg.nm <= d1_side.clamp ? d1_quo : d1_side.v.nm;
            e_reg.nn <= d1_side.v.nn;
            e_reg.nl <= d1_side.clamp ? LW'(maxd_reg) : d1_side.nl;
            e_reg.pl <= d1_side.pl;
            e_pm_reg <= d1_side.v.pm;
            e_pn_reg <= d1_side.v.pn;

            f_reg     <= e_reg;
            f_xs_reg  <= e_pn_reg ^ e_reg.nn;
            f_den_reg <= e_reg.pl * e_reg.nl;
            for (int i = 0; i < 3; i++)
            begin
                f_t_reg[i] <= e_pm_reg[i] * e_reg.nm[i];
            end

            g1_reg     <= f_reg;
            g1_den_reg <= f_den_reg;
            g1_dot_reg <= (f_xs_reg[0] ? 64'd0 - f_t_reg[0] : f_t_reg[0])
                        + (f_xs_reg[1] ? 64'd0 - f_t_reg[1] : f_t_reg[1])
                        + (f_xs_reg[2] ? 64'd0 - f_t_reg[2] : f_t_reg[2]);

            g2_reg.c      <= g1_reg;
            g2_reg.dneg   <= g1_dot_reg[63];
            g2_reg.sat    <= g2_adot_next >= g1_den_reg;
            g2_reg.active <= (g1_reg.pl != '0) && (g1_reg.nl != '0);
            g2_adot_reg   <= g2_adot_next;
            g2_den_reg    <= g1_den_reg;
        end
    end

    assign g2_adot_next = g1_dot_reg[63] ? 64'd0 - g1_dot_reg : g1_dot_reg;

    always_comb
    begin
        if (g2_reg.active && !g2_reg.sat)
        begin
            fr_num[0] = {g2_adot_reg, CB'(0)};
            fr_den    = g2_den_reg;
        end
        else
        begin
            fr_num[0] = '0;
            fr_den    = 64'd1;
        end
    end

    dod_div #(
        .LANES (1),
        .NW    (CB + 64),
        .DW    (64),
        .QW    (CB),
        .SW    (FR_SW)
    ) u_div_cos (
        .clk      (clk),
        .en       (adv),
        .num      (fr_num),
        .den      (fr_den),
        .side_in  (g2_reg),
        .quo      (fr_quo),
        .side_out (fr_side)
    );

    // damping factor and limit
    assign h_cmag = fr_side.sat ? dod_pkg::COS_ONE : {1'b0, fr_quo[0]};
    assign i_fsum = (CB + 4)'(dod_pkg::COS_ONE) + (CB + 4)'(h_sq_reg[2*CB+1:CB+1]);
    assign i_f    = h_dneg_reg ? i_fsum - (CB + 4)'(h_lin_reg[2*CB+1:CB])
                               : i_fsum + (CB + 4)'(h_lin_reg[2*CB+1:CB]);
    assign j_prod = i_reg.pl * i_f_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg        <= fr_side.c;
            h_dneg_reg   <= fr_side.dneg;
            h_active_reg <= fr_side.active;
            h_sq_reg     <= h_cmag * h_cmag;
            h_lin_reg    <= h_cmag * dod_pkg::ONE_POINT_TWO;

            i_reg        <= h_reg;
            i_active_reg <= h_active_reg;
            i_f_reg      <= i_f[LW-1:0];

            j_reg        <= i_reg;
            j_active_reg <= i_active_reg;
            j_lim_reg    <= j_prod[63:CB];

            k_reg.nm   <= j_reg.nm;
            k_reg.nn   <= j_reg.nn;
            k_reg.damp <= j_active_reg && (dod_pkg::LIM_W'(j_reg.nl) > j_lim_reg);
            k_nl_reg   <= j_reg.nl;
            for (int i = 0; i < 3; i++)
            begin
                k_prod_reg[i] <= j_reg.nm[i] * j_lim_reg[LW-1:0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d2_num[i] = k_reg.damp ? k_prod_reg[i] : 64'd0;
        end
        d2_den = k_reg.damp ? k_nl_reg : LW'(1);
    end

    dod_div #(
        .LANES (3),
        .NW    (64),
        .DW    (LW),
        .QW    (LW),
        .SW    (OS_SW)
    ) u_div_damp (
        .clk      (clk),
        .en       (adv),
        .num      (d2_num),
        .den      (d2_den),
        .side_in  (k_reg),
        .quo      (d2_quo),
        .side_out (d2_side)
    );

    // result, write back and output register
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_mag[i] = d2_side.damp ? d2_quo[i] : d2_side.nm[i];
            res[i]     = d2_side.nn[i] ? LW'(0) - res_mag[i] : res_mag[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign damped_x  = signed'(out_res_reg[0]);
    assign damped_y  = signed'(out_res_reg[1]);
    assign damped_z  = signed'(out_res_reg[2]);

    // checks
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !tag_vld_reg[0] && !tag_vld_reg[LAST])
        else $error("item in flight during clearing pass");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("clearing pass restarted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result changed");

    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_ok |-> !(tag_vld_reg[LAST] && tag_ok_reg[LAST]
            && tag_idx_reg[LAST] == node_index))
        else $error("read of node with write back pending");

endmodule
